>>> hw/rtl/sur_pkg.sv
`default_nettype none

package sur_pkg;

    localparam int RANK_W  = 41;
    localparam int LOW_W   = 64;
    localparam int HIGH_W  = 17;
    localparam int MASK_W  = LOW_W + HIGH_W;
    localparam int BINOM_W = 64;

    typedef enum logic [2:0] {
        S_WAIT_FILL,
        S_IDLE,
        S_RANK,
        S_DRAIN,
        S_URANGE,
        S_UPROBE
    } t_state;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_COUNT = 2'd1,
        STAT_RANGE = 2'd2
    } t_status;

    typedef enum logic {
        REQ_RANK   = 1'b0,
        REQ_UNRANK = 1'b1
    } t_req;

    typedef enum logic [1:0] {
        SYM_IDENT     = 2'd0,
        SYM_TRANSPOSE = 2'd1,
        SYM_ROT180    = 2'd2,
        SYM_ANTI      = 2'd3
    } t_sym;

endpackage

`default_nettype wire

>>> hw/rtl/sur_ram.sv
`default_nettype none

module sur_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 902
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hw/rtl/sur_fill.sv
`default_nettype none

module sur_fill #(
    parameter int SIDE   = 9,
    parameter int STONES = 10
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    output logic                       o_we,
    output logic [$clog2((STONES + 1) * (SIDE * SIDE + 1))-1:0] o_waddr,
    output logic [sur_pkg::BINOM_W-1:0] o_wdata,
    output logic                       o_done
);

    localparam int CELLS = SIDE * SIDE;
    localparam int DEPTH = (STONES + 1) * (CELLS + 1);
    localparam int AW    = $clog2(DEPTH);
    localparam int JW    = $clog2(CELLS + 1);
    localparam int KW    = $clog2(STONES + 1);

    // One column of Pascal's triangle, C(j,0) .. C(j,STONES), is held here and
    // written out one entry per cycle before it advances to column j+1.
    logic [sur_pkg::BINOM_W-1:0] r_row [STONES + 1];
    logic [sur_pkg::BINOM_W-1:0] n_row [STONES + 1];
    logic [JW-1:0]               r_j, n_j;
    logic [KW-1:0]               r_i, n_i;
    logic [AW-1:0]               r_addr, n_addr;
    logic                        r_done, n_done;

    always_comb begin
        n_row  = r_row;
        n_j    = r_j;
        n_i    = r_i;
        n_addr = r_addr;
        n_done = r_done;
        if (!r_done) begin
            n_addr = r_addr + AW'(1);
            if (r_i == KW'(STONES)) begin
                n_i = '0;
                if (r_j == JW'(CELLS)) begin
                    n_done = 1'b1;
                end else begin
                    n_j = r_j + JW'(1);
                end
                n_row[0] = sur_pkg::BINOM_W'(1);
                for (int k = 1; k <= STONES; k++) begin
                    n_row[k] = r_row[k] + r_row[k - 1];
                end
            end else begin
                n_i = r_i + KW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j    <= '0;
            r_i    <= '0;
            r_addr <= '0;
            r_done <= 1'b0;
            for (int k = 0; k <= STONES; k++) begin
                r_row[k] <= (k == 0) ? sur_pkg::BINOM_W'(1) : '0;
            end
        end else begin
            r_j    <= n_j;
            r_i    <= n_i;
            r_addr <= n_addr;
            r_done <= n_done;
            r_row  <= n_row;
        end
    end

    assign o_we    = !r_done;
    assign o_waddr = r_addr;
    assign o_wdata = r_row[r_i];
    assign o_done  = r_done;

endmodule

`default_nettype wire

>>> hw/rtl/sur_engine.sv
`default_nettype none

module sur_engine #(
    parameter int SIDE   = 9,
    parameter int STONES = 10
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_fill_done,
    input  wire logic                          i_start,
    input  wire logic                          i_req_type,
    input  wire logic [1:0]                    i_symmetry,
    input  wire logic [sur_pkg::LOW_W-1:0]     i_mask_low,
    input  wire logic [sur_pkg::HIGH_W-1:0]    i_mask_high,
    input  wire logic [sur_pkg::RANK_W-1:0]    i_rank_in,
    output logic                               o_busy,
    output logic                               o_re,
    output logic [$clog2((STONES + 1) * (SIDE * SIDE + 1))-1:0] o_raddr,
    input  wire logic [sur_pkg::BINOM_W-1:0]   i_rdata,
    output logic                               o_valid,
    output logic [sur_pkg::RANK_W-1:0]         o_rank_out,
    output logic [sur_pkg::LOW_W-1:0]          o_cells_low,
    output logic [sur_pkg::HIGH_W-1:0]         o_cells_high,
    output logic [1:0]                         o_status
);

    localparam int CELLS  = SIDE * SIDE;
    localparam int STRIDE = STONES + 1;
    localparam int DEPTH  = STRIDE * (CELLS + 1);
    localparam int AW     = $clog2(DEPTH);
    localparam int CW     = $clog2(CELLS);
    localparam int SW     = $clog2(SIDE);
    localparam int KW     = $clog2(STONES + 1);
    localparam int NW     = $clog2(CELLS + 1);
    localparam int RW     = sur_pkg::RANK_W;
    localparam int MW     = sur_pkg::MASK_W;
    localparam int BW     = sur_pkg::BINOM_W;

    sur_pkg::t_state  r_state, n_state;
    sur_pkg::t_req    r_req, n_req;
    sur_pkg::t_sym    r_sym, n_sym;
    logic [MW-1:0]    r_mask, n_mask;
    logic [RW-1:0]    r_rank, n_rank;
    logic [RW-1:0]    r_acc, n_acc;
    logic [MW-1:0]    r_cells, n_cells;
    logic [CW-1:0]    r_pos, n_pos;
    logic [SW-1:0]    r_a, n_a;
    logic [SW-1:0]    r_b, n_b;
    logic [AW-1:0]    r_base, n_base;
    logic [AW-1:0]    r_addr, n_addr;
    logic [KW-1:0]    r_k, n_k;
    logic [NW-1:0]    r_cnt, n_cnt;
    logic             r_pend, n_pend;
    logic             r_valid, n_valid;
    logic [RW-1:0]    r_out_rank, n_out_rank;
    logic [MW-1:0]    r_out_cells, n_out_cells;
    sur_pkg::t_status r_out_status, n_out_status;

    logic [CW-1:0]    w_cell;
    logic             w_bit;
    logic             w_hit;
    logic [MW-1:0]    w_cells_set;
    logic [RW-1:0]    w_acc_final;
    logic [AW-1:0]    w_raddr;

    // The scan walks position pos = b*SIDE + a downward; the oriented cell is
    // formed from pos or from the row and column counters, by symmetry mode.
    always_comb begin
        unique case (r_sym)
            sur_pkg::SYM_TRANSPOSE: w_cell = CW'(int'(r_a) * SIDE + int'(r_b));
            sur_pkg::SYM_ROT180:    w_cell = CW'(CELLS - 1 - int'(r_pos));
            sur_pkg::SYM_ANTI:      w_cell = CW'((SIDE - 1 - int'(r_a)) * SIDE
                                                 + (SIDE - 1 - int'(r_b)));
            sur_pkg::SYM_IDENT:     w_cell = r_pos;
        endcase
    end

    assign w_bit       = r_mask[w_cell];
    assign w_hit       = {{(BW - RW){1'b0}}, r_rank} >= i_rdata;
    assign w_cells_set = r_cells | (MW'(1) << r_pos);
    assign w_acc_final = r_pend ? (r_acc + i_rdata[RW-1:0]) : r_acc;

    always_comb begin
        n_state      = r_state;
        n_req        = r_req;
        n_sym        = r_sym;
        n_mask       = r_mask;
        n_rank       = r_rank;
        n_acc        = r_acc;
        n_cells      = r_cells;
        n_pos        = r_pos;
        n_a          = r_a;
        n_b          = r_b;
        n_base       = r_base;
        n_addr       = r_addr;
        n_k          = r_k;
        n_cnt        = r_cnt;
        n_pend       = r_pend;
        n_valid      = 1'b0;
        n_out_rank   = r_out_rank;
        n_out_cells  = r_out_cells;
        n_out_status = r_out_status;
        o_re         = 1'b0;
        w_raddr      = r_addr;

        unique case (r_state)
            sur_pkg::S_WAIT_FILL: begin
                if (i_fill_done) begin
                    n_state = sur_pkg::S_IDLE;
                end
            end
            sur_pkg::S_IDLE: begin
                if (i_start) begin
                    n_req  = sur_pkg::t_req'(i_req_type);
                    n_sym  = sur_pkg::t_sym'(i_symmetry);
                    n_mask = {i_mask_high, i_mask_low};
                    n_rank = i_rank_in;
                    n_k    = KW'(STONES);
                    n_pos  = CW'(CELLS - 1);
                    if (sur_pkg::t_req'(i_req_type) == sur_pkg::REQ_RANK) begin
                        n_a     = SW'(SIDE - 1);
                        n_b     = SW'(SIDE - 1);
                        n_base  = AW'((CELLS - 1) * STRIDE);
                        n_cnt   = '0;
                        n_acc   = '0;
                        n_pend  = 1'b0;
                        n_state = sur_pkg::S_RANK;
                    end else begin
                        o_re    = 1'b1;
                        w_raddr = AW'(CELLS * STRIDE + STONES);
                        n_addr  = w_raddr;
                        n_cells = '0;
                        n_state = sur_pkg::S_URANGE;
                    end
                end
            end
            sur_pkg::S_RANK: begin
                n_pend = 1'b0;
                if (r_pend) begin
                    n_acc = r_acc + i_rdata[RW-1:0];
                end
                if (w_bit) begin
                    n_cnt = r_cnt + NW'(1);
                    if (r_k != '0) begin
                        o_re    = 1'b1;
                        w_raddr = r_base + AW'(r_k);
                        n_k     = r_k - KW'(1);
                        n_pend  = 1'b1;
                    end
                end
                if (r_pos == '0) begin
                    n_state = sur_pkg::S_DRAIN;
                end else begin
                    n_pos  = r_pos - CW'(1);
                    n_base = r_base - AW'(STRIDE);
                    if (r_a == '0) begin
                        n_a = SW'(SIDE - 1);
                        n_b = r_b - SW'(1);
                    end else begin
                        n_a = r_a - SW'(1);
                    end
                end
            end
            sur_pkg::S_DRAIN: begin
                n_valid     = 1'b1;
                n_state     = sur_pkg::S_IDLE;
                n_out_cells = '0;
                if (int'(r_cnt) != STONES) begin
                    n_out_status = sur_pkg::STAT_COUNT;
                    n_out_rank   = '0;
                end else begin
                    n_out_status = sur_pkg::STAT_OK;
                    n_out_rank   = w_acc_final;
                end
            end
            sur_pkg::S_URANGE: begin
                if (w_hit) begin
                    n_valid      = 1'b1;
                    n_state      = sur_pkg::S_IDLE;
                    n_out_status = sur_pkg::STAT_RANGE;
                    n_out_rank   = '0;
                    n_out_cells  = '0;
                end else begin
                    o_re    = 1'b1;
                    w_raddr = r_addr - AW'(STRIDE);
                    n_addr  = w_raddr;
                    n_state = sur_pkg::S_UPROBE;
                end
            end
            sur_pkg::S_UPROBE: begin
                if (w_hit) begin
                    n_rank  = r_rank - i_rdata[RW-1:0];
                    n_cells = w_cells_set;
                    if (r_k == KW'(1)) begin
                        n_valid      = 1'b1;
                        n_state      = sur_pkg::S_IDLE;
                        n_out_status = sur_pkg::STAT_OK;
                        n_out_rank   = '0;
                        n_out_cells  = w_cells_set;
                    end else begin
                        o_re    = 1'b1;
                        w_raddr = r_addr - AW'(STRIDE + 1);
                        n_addr  = w_raddr;
                        n_k     = r_k - KW'(1);
                        n_pos   = r_pos - CW'(1);
                    end
                end else if (r_pos == '0) begin
                    n_valid      = 1'b1;
                    n_state      = sur_pkg::S_IDLE;
                    n_out_status = sur_pkg::STAT_OK;
                    n_out_rank   = '0;
                    n_out_cells  = r_cells;
                end else begin
                    o_re    = 1'b1;
                    w_raddr = r_addr - AW'(STRIDE);
                    n_addr  = w_raddr;
                    n_pos   = r_pos - CW'(1);
                end
            end
            default: begin
                n_state = sur_pkg::S_WAIT_FILL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sur_pkg::S_WAIT_FILL;
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
            r_sym   <= sur_pkg::SYM_IDENT;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_pend  <= n_pend;
            r_sym   <= n_sym;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_mask       <= n_mask;
        r_rank       <= n_rank;
        r_acc        <= n_acc;
        r_cells      <= n_cells;
        r_pos        <= n_pos;
        r_a          <= n_a;
        r_b          <= n_b;
        r_base       <= n_base;
        r_addr       <= n_addr;
        r_k          <= n_k;
        r_cnt        <= n_cnt;
        r_out_rank   <= n_out_rank;
        r_out_cells  <= n_out_cells;
        r_out_status <= n_out_status;
    end

    assign o_busy       = (r_state != sur_pkg::S_IDLE);
    assign o_raddr      = w_raddr;
    assign o_valid      = r_valid;
    assign o_rank_out   = r_out_rank;
    assign o_cells_low  = r_out_cells[sur_pkg::LOW_W-1:0];
    assign o_cells_high = r_out_cells[MW-1:sur_pkg::LOW_W];
    assign o_status     = r_out_status;

    a_start_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sur_pkg::S_IDLE && i_start) |=> (r_state != sur_pkg::S_IDLE))
        else $error("Accepted word did not start a job.");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_out_status != sur_pkg::STAT_OK)
            |-> (r_out_rank == '0 && r_out_cells == '0))
        else $error("Error result carries nonzero payload.");

    a_unrank_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_req == sur_pkg::REQ_UNRANK && r_out_status == sur_pkg::STAT_OK)
            |-> ($countones(r_out_cells) == STONES))
        else $error("Unranked mask has the wrong number of cells.");

    a_table_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != sur_pkg::S_WAIT_FILL) |-> i_fill_done)
        else $error("Engine left the fill wait before the table was complete.");

endmodule

`default_nettype wire

>>> hw/rtl/subset_rank_unrank.sv
// Channel   Direction  Ports                                              Handshake
// request   in         i_req_type i_symmetry i_mask_low i_mask_high      start, busy
//                      i_rank_in
// result    out        o_rank_out o_cells_low o_cells_high o_status      o_valid strobe
//
// After reset the binomial table memory is filled one entry per cycle until all of its
// (STONE_COUNT+1)*(BOARD_SIDE^2+1) entries (902 by default) are written; busy stays
// high until then. A rank word scans one cell per cycle with one table read per
// stone. An unrank word makes one table probe per cycle on the single read port and
// stops after its first probe when the rank is out of range.
// One word is in flight at a time; the result strobe cannot be stalled.

`default_nettype none

module subset_rank_unrank #(
    parameter int BOARD_SIDE  = 9,
    parameter int STONE_COUNT = 10
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_req_type,
    input  wire logic [1:0]                    i_symmetry,
    input  wire logic [sur_pkg::LOW_W-1:0]     i_mask_low,
    input  wire logic [sur_pkg::HIGH_W-1:0]    i_mask_high,
    input  wire logic [sur_pkg::RANK_W-1:0]    i_rank_in,
    output logic                               o_valid,
    output logic [sur_pkg::RANK_W-1:0]         o_rank_out,
    output logic [sur_pkg::LOW_W-1:0]          o_cells_low,
    output logic [sur_pkg::HIGH_W-1:0]         o_cells_high,
    output logic [1:0]                         o_status
);

    localparam int CELLS = BOARD_SIDE * BOARD_SIDE;
    localparam int DEPTH = (STONE_COUNT + 1) * (CELLS + 1);
    localparam int AW    = $clog2(DEPTH);

    logic                         w_we;
    logic [AW-1:0]                w_waddr;
    logic [sur_pkg::BINOM_W-1:0]  w_wdata;
    logic                         w_fill_done;
    logic                         w_re;
    logic [AW-1:0]                w_raddr;
    logic [sur_pkg::BINOM_W-1:0]  w_rdata;

    sur_fill #(
        .SIDE   (BOARD_SIDE),
        .STONES (STONE_COUNT)
    ) u_fill (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .o_we    (w_we),
        .o_waddr (w_waddr),
        .o_wdata (w_wdata),
        .o_done  (w_fill_done)
    );

    sur_ram #(
        .WIDTH (sur_pkg::BINOM_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    sur_engine #(
        .SIDE   (BOARD_SIDE),
        .STONES (STONE_COUNT)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fill_done  (w_fill_done),
        .i_start      (start),
        .i_req_type   (i_req_type),
        .i_symmetry   (i_symmetry),
        .i_mask_low   (i_mask_low),
        .i_mask_high  (i_mask_high),
        .i_rank_in    (i_rank_in),
        .o_busy       (busy),
        .o_re         (w_re),
        .o_raddr      (w_raddr),
        .i_rdata      (w_rdata),
        .o_valid      (o_valid),
        .o_rank_out   (o_rank_out),
        .o_cells_low  (o_cells_low),
        .o_cells_high (o_cells_high),
        .o_status     (o_status)
    );

endmodule

`default_nettype wire
